// ===== src/overwrite_oldest_byte_ring_defines.svh =====
// ---------------------------------------------------------------------------
// overwrite_oldest_byte_ring assertion macros
// shared property wrappers, clocked on the rising edge, off during reset
// ---------------------------------------------------------------------------
`ifndef OVERWRITE_OLDEST_BYTE_RING_DEFINES_SVH
`define OVERWRITE_OLDEST_BYTE_RING_DEFINES_SVH

// same-cycle implication
`define OBR_ASSERT_IMP(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("obr assertion failed");

// next-cycle implication
`define OBR_ASSERT_NXT(name, clk_s, rst_s, ante, cons) \
  name: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("obr assertion failed");

`endif

// ===== src/obr_pkg.sv =====
// ---------------------------------------------------------------------------
// obr_pkg
// types and constants shared by the byte ring modules
// ---------------------------------------------------------------------------
`default_nettype none

package obr_pkg;

  typedef enum logic [2:0] {
    ACT_WRITE     = 3'd0,
    ACT_REC_START = 3'd1,
    ACT_REC_BYTE  = 3'd2,
    ACT_READ      = 3'd3,
    ACT_PEEK      = 3'd4,
    ACT_RESET     = 3'd5
  } action_t;

  localparam logic [3:0] SIZE_LOG2_RESET = 4'd12;

  // status that travels with one result
  typedef struct packed {
    logic        data_valid;
    logic        record_accepted;
    logic [12:0] fill_level;
    logic [31:0] overruns;
    logic [31:0] underruns;
    logic [47:0] bytes_produced;
  } status_t;

endpackage

`default_nettype wire

// ===== src/obr_mem.sv =====
// ---------------------------------------------------------------------------
// obr_mem
// byte store, one write port and one read port, registered read data
// ---------------------------------------------------------------------------
`default_nettype none

module obr_mem #(
  parameter int ADDR_W = 12
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [7:0]        rd_data
);

  logic [7:0] store [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      store[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rd_data <= store[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/obr_ctrl.sv =====
// ---------------------------------------------------------------------------
// obr_ctrl
// pointers, fill, counters and record tracking; issues store accesses
// ---------------------------------------------------------------------------
`default_nettype none
`include "overwrite_oldest_byte_ring_defines.svh"

module obr_ctrl #(
  parameter int DEPTH_LOG2 = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr,
  input  wire logic [3:0]            cfg_data,
  input  wire logic                  accept,
  input  wire logic [2:0]            action,
  input  wire logic [7:0]            data_in,
  input  wire logic                  starts_call,
  input  wire logic [15:0]           record_length,
  input  wire logic [11:0]           peek_offset,
  output logic                       mem_we,
  output logic      [DEPTH_LOG2-1:0] mem_waddr,
  output logic      [7:0]            mem_wdata,
  output logic                       mem_re,
  output logic      [DEPTH_LOG2-1:0] mem_raddr,
  output obr_pkg::status_t           status
);

  import obr_pkg::*;

  localparam int FW = DEPTH_LOG2 + 1;
  localparam int CW = (FW > 16) ? FW : 16;
  localparam int PW = (DEPTH_LOG2 > 12) ? DEPTH_LOG2 : 12;

  logic [3:0]            size_log2;
  logic [DEPTH_LOG2-1:0] rp, rp_next;
  logic [DEPTH_LOG2-1:0] wp, wp_next;
  logic [FW-1:0]         fill, fill_next;
  logic [31:0]           ovr, ovr_next;
  logic [31:0]           unr, unr_next;
  logic [47:0]           prod, prod_next;
  logic                  ever, ever_next;
  logic                  otc, otc_next;
  logic [15:0]           rr, rr_next;

  logic [4:0]            lg;
  logic [FW-1:0]         cap;
  logic [DEPTH_LOG2-1:0] mask;
  logic [DEPTH_LOG2-1:0] rp_inc;
  logic [DEPTH_LOG2-1:0] wp_inc;
  logic [FW-1:0]         free;
  logic                  full;
  logic                  rec_fits;
  logic                  peek_hit;
  logic [PW-1:0]         peek_sum;
  logic [DEPTH_LOG2-1:0] peek_addr;
  logic [FW-1:0]         wrap_sum;
  action_t               act;

  // clamp size into 1..DEPTH_LOG2
  always_comb begin
    if (size_log2 == 4'd0) begin
      lg = 5'd1;
    end else if (32'(size_log2) > DEPTH_LOG2) begin
      lg = 5'(DEPTH_LOG2);
    end else begin
      lg = {1'b0, size_log2};
    end
  end

  assign cap       = FW'(1) << lg;
  assign mask      = DEPTH_LOG2'(cap - FW'(1));
  assign rp_inc    = DEPTH_LOG2'(rp + 1'b1) & mask;
  assign wp_inc    = DEPTH_LOG2'(wp + 1'b1) & mask;
  assign free      = cap - fill;
  assign full      = (fill >= cap);
  assign rec_fits  = (CW'(record_length) <= CW'(free));
  assign peek_hit  = (CW'(peek_offset) < CW'(fill));
  assign peek_sum  = PW'(rp) + PW'(peek_offset);
  assign peek_addr = peek_sum[DEPTH_LOG2-1:0] & mask;
  assign wrap_sum  = FW'(rp) + fill;
  assign act       = action_t'(action);
  assign mem_wdata = data_in;

  always_comb begin
    logic otc_v;
    otc_v       = otc;
    rp_next     = rp;
    wp_next     = wp;
    fill_next   = fill;
    ovr_next    = ovr;
    unr_next    = unr;
    prod_next   = prod;
    ever_next   = ever;
    otc_next    = otc;
    rr_next     = rr;
    mem_we      = 1'b0;
    mem_waddr   = wp;
    mem_re      = 1'b0;
    mem_raddr   = rp;
    status.data_valid      = 1'b0;
    status.record_accepted = 1'b0;
    if (accept) begin
      case (act)
        ACT_WRITE: begin
          if (starts_call) begin
            otc_v = 1'b0;
          end
          prod_next = prod + 48'd1;
          ever_next = 1'b1;
          mem_we    = 1'b1;
          wp_next   = wp_inc;
          if (full) begin
            // drop oldest, fill stays at capacity
            rp_next = rp_inc;
            if (!otc_v) begin
              ovr_next = ovr + 32'd1;
              otc_v    = 1'b1;
            end
          end else begin
            fill_next = fill + 1'b1;
          end
          otc_next = otc_v;
        end
        ACT_REC_START: begin
          if (rec_fits) begin
            status.record_accepted = 1'b1;
            rr_next   = record_length;
            prod_next = prod + 48'(record_length);
            if (record_length != 16'd0) begin
              ever_next = 1'b1;
            end
          end else begin
            rr_next = 16'd0;
          end
        end
        ACT_REC_BYTE: begin
          if (rr != 16'd0) begin
            rr_next = rr - 16'd1;
            if (!full) begin
              mem_we    = 1'b1;
              wp_next   = wp_inc;
              fill_next = fill + 1'b1;
            end
          end
        end
        ACT_READ: begin
          if (fill == '0) begin
            if (starts_call && ever) begin
              unr_next = unr + 32'd1;
            end
          end else begin
            mem_re            = 1'b1;
            status.data_valid = 1'b1;
            rp_next           = rp_inc;
            fill_next         = fill - 1'b1;
          end
        end
        ACT_PEEK: begin
          if (peek_hit) begin
            mem_re            = 1'b1;
            mem_raddr         = peek_addr;
            status.data_valid = 1'b1;
          end
        end
        ACT_RESET: begin
          rp_next   = '0;
          wp_next   = '0;
          fill_next = '0;
        end
        default: begin
        end
      endcase
    end
    status.fill_level     = 13'(fill_next);
    status.overruns       = ovr_next;
    status.underruns      = unr_next;
    status.bytes_produced = prod_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2 <= SIZE_LOG2_RESET;
      rp        <= '0;
      wp        <= '0;
      fill      <= '0;
      ovr       <= '0;
      unr       <= '0;
      prod      <= '0;
      ever      <= 1'b0;
      otc       <= 1'b0;
      rr        <= '0;
    end else begin
      rp   <= rp_next;
      wp   <= wp_next;
      fill <= fill_next;
      ovr  <= ovr_next;
      unr  <= unr_next;
      prod <= prod_next;
      ever <= ever_next;
      otc  <= otc_next;
      rr   <= rr_next;
      // size change empties the ring and closes any record
      if (cfg_wr) begin
        size_log2 <= cfg_data;
        rp        <= '0;
        wp        <= '0;
        fill      <= '0;
        rr        <= '0;
      end
    end
  end

  `OBR_ASSERT_IMP(a_fill_le_cap, clk, rst, 1'b1, fill <= cap)
  `OBR_ASSERT_IMP(a_wp_tracks_fill, clk, rst, 1'b1, wp == (wrap_sum[DEPTH_LOG2-1:0] & mask))
  `OBR_ASSERT_IMP(a_one_port_use, clk, rst, 1'b1, !(mem_we && mem_re))

endmodule

`default_nettype wire

// ===== src/obr_out.sv =====
// ---------------------------------------------------------------------------
// obr_out
// result pipeline: status registered beside the store read, then output register
// ---------------------------------------------------------------------------
`default_nettype none
`include "overwrite_oldest_byte_ring_defines.svh"

module obr_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             issue,
  input  wire obr_pkg::status_t status,
  input  wire logic [7:0]       rd_data,
  output logic                  can_issue,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [7:0]       res_data,
  output obr_pkg::status_t      res
);

  import obr_pkg::*;

  logic    s1_valid;
  status_t s1_status;
  logic    s1_move;

  assign s1_move   = s1_valid && (!out_valid || out_ready);
  assign can_issue = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_status <= status;
    end
    // store data is only meaningful for a read or peek that hit
    if (s1_move) begin
      res      <= s1_status;
      res_data <= s1_status.data_valid ? rd_data : 8'd0;
    end
  end

  `OBR_ASSERT_NXT(a_issue_lands, clk, rst, issue, s1_valid)
  `OBR_ASSERT_NXT(a_move_shows, clk, rst, s1_move, out_valid)
  `OBR_ASSERT_IMP(a_no_overrun_s1, clk, rst, issue, can_issue)

endmodule

`default_nettype wire

// ===== src/overwrite_oldest_byte_ring.sv =====
// ---------------------------------------------------------------------------
// overwrite_oldest_byte_ring
// byte ring that drops the oldest byte on a full stream write
// ---------------------------------------------------------------------------
// usage:
//   input channel (in_valid/in_ready) carries one action per transaction:
//   stream write, record start, record byte, read, peek or pointer reset.
//   output channel (out_valid/out_ready) returns exactly one result per
//   input transaction, in order, with the status after that action.
//   config channel (cfg_valid/cfg_ready) writes size_log2; it empties the
//   ring and closes any open record. write it only while the block is idle.
// result path: read data and status are registered, then the output register.
// throughput: one transaction per cycle while out_ready is high and no
//   config write is pending, set by the store having one write port and
//   one read port and each action using at most one of them.
// reset: pointers, fill, counters and record state clear, size_log2 goes to
//   12; store contents are left as they are.
// stall: when out_ready is low, the output holds and one more result waits
//   inside, after which in_ready drops until the output is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module overwrite_oldest_byte_ring #(
  parameter int DEPTH_LOG2 = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [3:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  action,
  input  wire logic [7:0]  data_in,
  input  wire logic        starts_call,
  input  wire logic [15:0] record_length,
  input  wire logic [11:0] peek_offset,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [7:0]  data_out,
  output logic             data_valid,
  output logic             record_accepted,
  output logic      [12:0] fill_level,
  output logic      [31:0] overruns,
  output logic      [31:0] underruns,
  output logic      [47:0] bytes_produced
);

  import obr_pkg::*;

  logic                  cfg_wr;
  logic                  accept;
  logic                  can_issue;
  logic                  mem_we;
  logic [DEPTH_LOG2-1:0] mem_waddr;
  logic [7:0]            mem_wdata;
  logic                  mem_re;
  logic [DEPTH_LOG2-1:0] mem_raddr;
  logic [7:0]            rd_data;
  status_t               status;
  status_t               res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  // a config write takes the cycle, no transaction alongside it
  assign in_ready  = can_issue && !cfg_valid;
  assign accept    = in_valid && in_ready;

  obr_ctrl #(
    .DEPTH_LOG2 (DEPTH_LOG2)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr        (cfg_wr),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .action        (action),
    .data_in       (data_in),
    .starts_call   (starts_call),
    .record_length (record_length),
    .peek_offset   (peek_offset),
    .mem_we        (mem_we),
    .mem_waddr     (mem_waddr),
    .mem_wdata     (mem_wdata),
    .mem_re        (mem_re),
    .mem_raddr     (mem_raddr),
    .status        (status)
  );

  obr_mem #(
    .ADDR_W (DEPTH_LOG2)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rd_data (rd_data)
  );

  obr_out u_out (
    .clk       (clk),
    .rst       (rst),
    .issue     (accept),
    .status    (status),
    .rd_data   (rd_data),
    .can_issue (can_issue),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res_data  (data_out),
    .res       (res)
  );

  assign data_valid      = res.data_valid;
  assign record_accepted = res.record_accepted;
  assign fill_level      = res.fill_level;
  assign overruns        = res.overruns;
  assign underruns       = res.underruns;
  assign bytes_produced  = res.bytes_produced;

endmodule

`default_nettype wire
